// ===== sv/tbpe_pkg.sv =====
// Package for the Thumb-32 branch-with-link and push execute block.
// Holds the opcode, result kind and sequencer state codes and the result record.
// No dependencies.
`default_nettype none
package tbpe_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned IMM_W    = 11;
    localparam int unsigned LIST_W   = 13;
    localparam int unsigned REGS_W   = 15;  // r0..r14, bit 13 never set
    localparam int unsigned LR_IDX   = 14;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned RIDX_W   = 4;
    localparam int unsigned MIN_PUSH = 2;

    typedef enum logic [1:0] {
        OP_BL   = 2'd0,
        OP_BLX  = 2'd1,
        OP_PUSH = 2'd2,
        OP_UDF  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        K_BRANCH = 2'd0,
        K_STORE  = 2'd1,
        K_FAULT  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_TARGET,
        S_STORE,
        S_FAULT
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [XLEN-1:0]   target_pc;
        logic [XLEN-1:0]   link_value;
        logic              thumb_state;
        logic [XLEN-1:0]   store_address;
        logic [RIDX_W-1:0] store_reg;
        logic [XLEN-1:0]   new_stack_ptr;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/tbpe_in_if.sv =====
// Input channel carrying one decoded Thumb-32 instruction per transaction.
// Depends on tbpe_pkg for field widths.
`default_nettype none
interface tbpe_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [tbpe_pkg::IMM_W-1:0]     imm_high;
    logic [tbpe_pkg::IMM_W-1:0]     imm_low;
    logic                           push_link;
    logic [tbpe_pkg::LIST_W-1:0]    push_list;
    logic [tbpe_pkg::XLEN-1:0]      instr_pc;
    logic [tbpe_pkg::XLEN-1:0]      stack_ptr;

    modport source (output valid, opcode, imm_high, imm_low, push_link, push_list,
                    instr_pc, stack_ptr, input ready);
    modport sink   (input valid, opcode, imm_high, imm_low, push_link, push_list,
                    instr_pc, stack_ptr, output ready);
endinterface
`default_nettype wire

// ===== sv/tbpe_out_if.sv =====
// Output channel carrying one branch, store or fault result per transaction.
// Depends on tbpe_pkg for field widths.
`default_nettype none
interface tbpe_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic [tbpe_pkg::XLEN-1:0]      target_pc;
    logic [tbpe_pkg::XLEN-1:0]      link_value;
    logic                           thumb_state;
    logic [tbpe_pkg::XLEN-1:0]      store_address;
    logic [tbpe_pkg::RIDX_W-1:0]    store_reg;
    logic [tbpe_pkg::XLEN-1:0]      new_stack_ptr;
    logic                           last;

    modport source (output valid, kind, target_pc, link_value, thumb_state,
                    store_address, store_reg, new_stack_ptr, last, input ready);
    modport sink   (input valid, kind, target_pc, link_value, thumb_state,
                    store_address, store_reg, new_stack_ptr, last, output ready);
endinterface
`default_nettype wire

// ===== sv/thumb32_branch_push_execute.sv =====
// Top level of the Thumb-32 BL / BLX / PUSH.W execute block: sequencer, output register.
// Depends on tbpe_pkg, tbpe_in_if, tbpe_out_if and tbpe_alu.
// A BL or BLX result is computed in two steps, PC+4 in S_PREP and then the target in
// S_TARGET, before it enters the output register; a fault result passes through S_PREP
// and S_FAULT. A PUSH computes the new stack pointer in S_PREP, then S_STORE gives one
// store per cycle while the output is not stalled, up to fourteen registers.
// All sums go through the single shared 32-bit adder, one per cycle, and the
// block takes no new instruction until the last result of the current one has entered
// the output register. That register lets the next instruction be accepted in the next
// cycle while the final result waits.
`default_nettype none
module thumb32_branch_push_execute (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tbpe_in_if.sink    i_item,
    tbpe_out_if.source o_res
);
    import tbpe_pkg::*;

    t_state                r_state, n_state;
    t_opcode               r_opcode, n_opcode;
    logic [IMM_W-1:0]      r_imm_high, n_imm_high;
    logic [IMM_W-1:0]      r_imm_low, n_imm_low;
    logic [REGS_W-1:0]     r_list, n_list;
    logic [XLEN-1:0]       r_pc, n_pc;
    logic [XLEN-1:0]       r_sp, n_sp;
    logic [XLEN-1:0]       r_acc, n_acc;
    logic [XLEN-1:0]       r_base, n_base;
    t_result               r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [XLEN-1:0]       alu_a, alu_b, alu_sum;
    logic                  alu_cin;
    logic [CNT_W-1:0]      reg_count;
    logic [RIDX_W-1:0]     low_idx;
    logic [REGS_W-1:0]     list_rest;
    logic [XLEN-1:0]       offset;
    logic                  slot_free;
    logic                  in_fire;

    tbpe_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_cin (alu_cin),
        .o_sum (alu_sum)
    );

    assign in_fire   = i_item.valid && i_item.ready;
    assign slot_free = !r_out_valid || o_res.ready;
    assign offset    = {{(XLEN-2*IMM_W-1){r_imm_high[IMM_W-1]}}, r_imm_high, r_imm_low, 1'b0};
    assign list_rest = r_list & (r_list - REGS_W'(1));

    always_comb begin
        reg_count = '0;
        for (int i = 0; i < REGS_W; i++) begin
            reg_count = reg_count + CNT_W'(r_list[i]);
        end
    end

    // Lowest set register goes out first.
    always_comb begin
        low_idx = '0;
        for (int i = REGS_W - 1; i >= 0; i--) begin
            if (r_list[i]) begin
                low_idx = RIDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode   <= n_opcode;
        r_imm_high <= n_imm_high;
        r_imm_low  <= n_imm_low;
        r_list     <= n_list;
        r_pc       <= n_pc;
        r_sp       <= n_sp;
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_opcode    = r_opcode;
        n_imm_high  = r_imm_high;
        n_imm_low   = r_imm_low;
        n_list      = r_list;
        n_pc        = r_pc;
        n_sp        = r_sp;
        n_acc       = r_acc;
        n_base      = r_base;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        alu_a       = r_acc;
        alu_b       = XLEN'(4);
        alu_cin     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_opcode   = t_opcode'(i_item.opcode);
                    n_imm_high = i_item.imm_high;
                    n_imm_low  = i_item.imm_low;
                    n_list     = {i_item.push_link, 1'b0, i_item.push_list};
                    n_pc       = i_item.instr_pc;
                    n_sp       = i_item.stack_ptr;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                unique case (r_opcode) inside
                    OP_BL, OP_BLX: begin
                        alu_a = r_pc;
                        n_acc = alu_sum;
                        if (r_opcode == OP_BLX && r_imm_low[0]) begin
                            n_state = S_FAULT;
                        end else begin
                            n_state = S_TARGET;
                        end
                    end
                    OP_PUSH: begin
                        // SP minus four times the count, as SP + ~(4n) + 1.
                        alu_a   = r_sp;
                        alu_b   = ~{{(XLEN-CNT_W-2){1'b0}}, reg_count, 2'b00};
                        alu_cin = 1'b1;
                        n_acc   = alu_sum;
                        n_base  = alu_sum;
                        if (reg_count < CNT_W'(MIN_PUSH)) begin
                            n_state = S_FAULT;
                        end else begin
                            n_state = S_STORE;
                        end
                    end
                    OP_UDF: begin
                        n_state = S_FAULT;
                    end
                    default: begin
                        n_state = S_FAULT;
                    end
                endcase
            end
            S_TARGET: begin
                alu_a = (r_opcode == OP_BL) ? r_acc : {r_acc[XLEN-1:2], 2'b00};
                alu_b = offset;
                if (slot_free) begin
                    n_out             = '0;
                    n_out.kind        = K_BRANCH;
                    n_out.target_pc   = alu_sum;
                    n_out.link_value  = r_acc | XLEN'(1);
                    n_out.thumb_state = (r_opcode == OP_BL);
                    n_out.last        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_STORE: begin
                if (slot_free) begin
                    n_out               = '0;
                    n_out.kind          = K_STORE;
                    n_out.store_address = r_acc;
                    n_out.store_reg     = low_idx;
                    n_out.new_stack_ptr = r_base;
                    n_out.last          = (list_rest == '0);
                    n_out_valid         = 1'b1;
                    n_acc               = alu_sum;
                    n_list              = list_rest;
                    if (list_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FAULT: begin
                if (slot_free) begin
                    n_out       = '0;
                    n_out.kind  = K_FAULT;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out.kind;
    assign o_res.target_pc     = r_out.target_pc;
    assign o_res.link_value    = r_out.link_value;
    assign o_res.thumb_state   = r_out.thumb_state;
    assign o_res.store_address = r_out.store_address;
    assign o_res.store_reg     = r_out.store_reg;
    assign o_res.new_stack_ptr = r_out.new_stack_ptr;
    assign o_res.last          = r_out.last;

    a_single_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != K_STORE |-> r_out.last)
        else $error("branch or fault result without last");

    a_store_aligned_to_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == K_STORE |->
            r_out.store_address[1:0] == r_out.new_stack_ptr[1:0])
        else $error("store address not word-spaced from new stack pointer");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && !in_fire |=> r_state == S_IDLE)
        else $error("sequencer left idle without a transaction");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.kind == K_BRANCH || r_out.kind == K_STORE
            || r_out.kind == K_FAULT)
        else $error("result carries an unused kind code");

endmodule
`default_nettype wire

// ===== sv/tbpe_alu.sv =====
// Shared 32-bit adder with carry in, used for every address computation.
// Depends on tbpe_pkg.
`default_nettype none
module tbpe_alu (
    input  wire logic [tbpe_pkg::XLEN-1:0] i_a,
    input  wire logic [tbpe_pkg::XLEN-1:0] i_b,
    input  wire logic                      i_cin,
    output logic [tbpe_pkg::XLEN-1:0]      o_sum
);
    import tbpe_pkg::*;

    assign o_sum = i_a + i_b + {{(XLEN-1){1'b0}}, i_cin};

endmodule
`default_nettype wire
